// ===== hdl/triangle_element_stiffness_assert.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers for the triangle element stiffness block.
// ============================================================================
`ifndef TRIANGLE_ELEMENT_STIFFNESS_ASSERT_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_ASSERT_SVH
`ifndef SYNTHESIS
`define TES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TES_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tes_pkg.sv =====
// ============================================================================
// tes_pkg
// Types, widths and helpers shared by the triangle element stiffness block.
// ============================================================================
package tes_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC      = 32;
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int WPROD_W       = 2 * DIFF_W;
    localparam int PROD_W        = 64;
    localparam int COEF_W        = 32;
    localparam int COEFA_W       = COEF_W + 2;
    localparam int PP_W          = 32 + COEFA_W;
    localparam int TERM_W        = PROD_W + COEFA_W;
    localparam int NUM_W         = TERM_W + 2;
    localparam int DIV_W         = 128;
    localparam int DET_W         = PROD_W + 2;
    localparam int DEN_W         = DET_W;
    localparam int REM_W         = DEN_W;
    localparam int QUO_W         = 64;
    localparam int DOF_W         = 3;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic        [DIFF_W-1:0]  mag_t;
    typedef logic        [WPROD_W-1:0] wprod_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [COEF_W-1:0]  coef_t;
    typedef logic        [COEFA_W-1:0] coefa_t;
    typedef logic        [PP_W-1:0]    pp_t;
    typedef logic        [TERM_W-1:0]  term_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic        [DIV_W-1:0]   udiv_t;
    typedef logic signed [DIV_W-1:0]   sdiv_t;
    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [REM_W-1:0]   rem_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic        [QUO_W:0]     qround_t;
    typedef logic signed [QUO_W-1:0]   value_t;
    typedef logic        [DOF_W-1:0]   dof_t;

    localparam dof_t   LAST_DOF    = dof_t'(5);
    localparam quo_t   SAT_POS     = {1'b0, {(QUO_W-1){1'b1}}};
    localparam quo_t   SAT_NEG_MAG = {1'b1, {(QUO_W-1){1'b0}}};

    typedef enum logic {
        REG_LAME_LAMBDA,
        REG_LAME_MU
    } reg_index_t;

    typedef struct packed {
        coord_t vertex0_x;
        coord_t vertex0_y;
        coord_t vertex1_x;
        coord_t vertex1_y;
        coord_t vertex2_x;
        coord_t vertex2_y;
    } vertex_item_t;

    typedef struct packed {
        dof_t   row_index;
        dof_t   col_index;
        value_t entry_value;
        logic   last_entry;
        logic   degenerate;
    } entry_item_t;

    typedef struct packed {
        dof_t row;
        dof_t col;
        logic last;
        logic degen;
    } div_tag_t;

    typedef struct packed {
        udiv_t    dividend;
        den_t     den;
        logic     neg;
        div_tag_t tag;
    } div_in_t;

    typedef struct packed {
        value_t   value;
        div_tag_t tag;
    } div_out_t;

    function automatic mag_t abs_diff(input diff_t v);
        return v[DIFF_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic diff_t pick3(input diff_t a0, input diff_t a1, input diff_t a2,
                                    input logic [1:0] sel);
        diff_t r;
        case (sel)
            2'd0:    r = a0;
            2'd1:    r = a1;
            default: r = a2;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tes_divider.sv =====
// ============================================================================
// tes_divider
// Pipelined restoring divider with round-to-nearest and signed saturation.
// ============================================================================
module tes_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  tes_pkg::div_in_t   div_in,
    output logic               out_valid,
    output tes_pkg::div_out_t  div_out
);

    localparam int STEPS = tes_pkg::QUO_W;

    logic               vld_reg  [0:STEPS+2];
    tes_pkg::rem_t      rem_reg  [0:STEPS];
    tes_pkg::quo_t      quo_reg  [0:STEPS];
    tes_pkg::quo_t      low_reg  [0:STEPS-1];
    tes_pkg::den_t      den_reg  [0:STEPS];
    logic               neg_reg  [0:STEPS+1];
    logic               sat_reg  [0:STEPS+1];
    tes_pkg::div_tag_t  tag_reg  [0:STEPS+2];
    tes_pkg::qround_t   qr_reg;
    tes_pkg::value_t    value_reg;

    tes_pkg::rem_t      rem_next [0:STEPS-1];
    tes_pkg::quo_t      quo_next [0:STEPS-1];
    logic [tes_pkg::REM_W:0] trial [0:STEPS-1];
    logic               ge       [0:STEPS-1];
    tes_pkg::quo_t      hi_part;
    logic               sat0_next;
    logic               half_ge;
    tes_pkg::qround_t   qr_next;
    tes_pkg::quo_t      limit;
    tes_pkg::quo_t      mag;
    tes_pkg::value_t    value_next;

    always_comb
    begin
        hi_part   = div_in.dividend[tes_pkg::DIV_W-1:tes_pkg::QUO_W];
        sat0_next = tes_pkg::den_t'(hi_part) >= div_in.den;
        for (int s = 0; s < STEPS; s++)
        begin
            trial[s]    = {rem_reg[s], low_reg[s][tes_pkg::QUO_W-1]};
            ge[s]       = trial[s] >= {1'b0, den_reg[s]};
            rem_next[s] = ge[s] ? tes_pkg::rem_t'(trial[s] - {1'b0, den_reg[s]})
                                : trial[s][tes_pkg::REM_W-1:0];
            quo_next[s] = {quo_reg[s][tes_pkg::QUO_W-2:0], ge[s]};
        end
        half_ge    = {rem_reg[STEPS], 1'b0} >= {1'b0, den_reg[STEPS]};
        qr_next    = {1'b0, quo_reg[STEPS]} + tes_pkg::qround_t'(half_ge);
        limit      = neg_reg[STEPS+1] ? tes_pkg::SAT_NEG_MAG : tes_pkg::SAT_POS;
        mag        = (sat_reg[STEPS+1] || (qr_reg > {1'b0, limit}))
                     ? limit : qr_reg[tes_pkg::QUO_W-1:0];
        value_next = neg_reg[STEPS+1] ? tes_pkg::value_t'(-mag) : tes_pkg::value_t'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STEPS + 2; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 0; s < STEPS + 2; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= tes_pkg::rem_t'(hi_part);
            quo_reg[0] <= '0;
            low_reg[0] <= div_in.dividend[tes_pkg::QUO_W-1:0];
            den_reg[0] <= div_in.den;
            neg_reg[0] <= div_in.neg;
            sat_reg[0] <= sat0_next;
            tag_reg[0] <= div_in.tag;
            for (int s = 0; s < STEPS; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                quo_reg[s+1] <= quo_next[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                sat_reg[s+1] <= sat_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
            for (int s = 0; s < STEPS - 1; s++)
            begin
                low_reg[s+1] <= {low_reg[s][tes_pkg::QUO_W-2:0], 1'b0};
            end
            qr_reg             <= qr_next;
            neg_reg[STEPS+1]   <= neg_reg[STEPS];
            sat_reg[STEPS+1]   <= sat_reg[STEPS];
            tag_reg[STEPS+1]   <= tag_reg[STEPS];
            value_reg          <= value_next;
            tag_reg[STEPS+2]   <= tag_reg[STEPS+1];
        end
    end

    assign out_valid = vld_reg[STEPS+2];
    assign div_out   = '{value: value_reg, tag: tag_reg[STEPS+2]};

endmodule

// ===== hdl/triangle_element_stiffness.sv =====
// ============================================================================
// triangle_element_stiffness
// Constant-strain triangle element stiffness matrix, fixed point.
// ============================================================================
// Each vertex item yields the 36 entries of the 6x6 stiffness matrix in
// row-major order, one entry per cycle while the entry channel is not
// stalled. Four setup stages form the edge vectors and determinant while the
// previous triangle is still being emitted; a sequencer then issues entries
// into a six-stage multiply pipeline and a 67-stage divider (a load stage, 64
// stages that each resolve one quotient bit, a rounding and a saturation
// stage). A stalled entry channel holds the sequencer and every stage after
// it; a full setup stage waits until the next stage can take its triangle.
// ============================================================================
`include "triangle_element_stiffness_assert.svh"

module triangle_element_stiffness #(
    parameter int FRAC_BITS = tes_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vertex_valid,
    output logic                          vertex_stall,
    input  tes_pkg::vertex_item_t         vertex_item,
    output logic                          entry_valid,
    input  logic                          entry_stall,
    output tes_pkg::entry_item_t          entry_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tes_pkg::ADDR_W-1:0]    paddr,
    input  logic [tes_pkg::DATA_W-1:0]    pwdata,
    output logic [tes_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int SHIFT = tes_pkg::OUT_FRAC - FRAC_BITS;
    localparam tes_pkg::coef_t COEF_ONE = tes_pkg::coef_t'(64'd1 << FRAC_BITS);

    // configuration
    tes_pkg::coef_t  lambda_reg;
    tes_pkg::coef_t  mu_reg;
    tes_pkg::coefa_t lp2;

    // setup stages
    logic                  p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    tes_pkg::vertex_item_t p1_item_reg;
    tes_pkg::diff_t        gb2_reg [3];
    tes_pkg::diff_t        gc2_reg [3];
    tes_pkg::diff_t        dx2_reg, dy1_reg;
    tes_pkg::diff_t        gb3_reg [3];
    tes_pkg::diff_t        gc3_reg [3];
    tes_pkg::prod_t        pa_reg, pb_reg;
    logic                  na_reg, nb_reg;
    tes_pkg::diff_t        gb4_reg [3];
    tes_pkg::diff_t        gc4_reg [3];
    tes_pkg::det_t         det_reg;
    tes_pkg::wprod_t       pa_full, pb_full;
    tes_pkg::det_t         ta, tb, det_next;
    logic                  en1, en2, en3, en4;

    // sequencer
    logic                  seq_vld_reg;
    tes_pkg::diff_t        gbs_reg [3];
    tes_pkg::diff_t        gcs_reg [3];
    tes_pkg::den_t         dens_reg;
    logic                  degens_reg;
    tes_pkg::dof_t         row_reg, col_reg;
    tes_pkg::dof_t         row_next, col_next;
    tes_pkg::det_t         abs_det;
    logic                  seq_last, seq_take, adv;

    // entry pipeline
    logic                  e_vld_reg [1:6];
    tes_pkg::div_tag_t     e_tag_reg [1:6];
    tes_pkg::den_t         e_den_reg [1:6];
    tes_pkg::diff_t        s_reg, t_reg, u_reg, v_reg;
    tes_pkg::coefa_t       ca1_reg, ca2_reg;
    tes_pkg::prod_t        m1_reg, m2_reg;
    logic                  n1_reg [2:4];
    logic                  n2_reg [2:4];
    tes_pkg::pp_t          alo_reg, ahi_reg, blo_reg, bhi_reg;
    tes_pkg::term_t        p1_reg, p2_reg;
    tes_pkg::num_t         num_reg;
    tes_pkg::udiv_t        mag_reg;
    logic                  neg6_reg;
    tes_pkg::diff_t        gbi, gbj, gci, gcj;
    logic                  row_odd, col_odd;
    tes_pkg::div_tag_t     tag1_next;
    tes_pkg::wprod_t       m1_full, m2_full;
    tes_pkg::num_t         num_next;
    tes_pkg::sdiv_t        shifted;
    tes_pkg::div_in_t      div_in;
    logic                  div_vld;
    tes_pkg::div_out_t     div_out;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= COEF_ONE;
            mu_reg     <= COEF_ONE;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (tes_pkg::reg_index_t'(paddr[2]))
                tes_pkg::REG_LAME_LAMBDA: lambda_reg <= pwdata;
                tes_pkg::REG_LAME_MU:     mu_reg     <= pwdata;
                default:                  ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (tes_pkg::reg_index_t'(paddr[2]) == tes_pkg::REG_LAME_MU) ? mu_reg
                                                                            : lambda_reg;
    assign lp2    = tes_pkg::coefa_t'(lambda_reg) + (tes_pkg::coefa_t'(mu_reg) << 1);

    // ------------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------------
    assign adv          = !entry_valid || !entry_stall;
    assign seq_last     = (row_reg == tes_pkg::LAST_DOF) && (col_reg == tes_pkg::LAST_DOF);
    assign seq_take     = !seq_vld_reg || (seq_last && adv);
    assign en4          = !p4_vld_reg || seq_take;
    assign en3          = !p3_vld_reg || en4;
    assign en2          = !p2_vld_reg || en3;
    assign en1          = !p1_vld_reg || en2;
    assign vertex_stall = !en1;

    // ------------------------------------------------------------------------
    // setup: edge vectors and determinant
    // ------------------------------------------------------------------------
    always_comb
    begin
        pa_full  = tes_pkg::wprod_t'(tes_pkg::abs_diff(gc2_reg[2]))
                 * tes_pkg::wprod_t'(tes_pkg::abs_diff(gb2_reg[1]));
        pb_full  = tes_pkg::wprod_t'(tes_pkg::abs_diff(dx2_reg))
                 * tes_pkg::wprod_t'(tes_pkg::abs_diff(dy1_reg));
        ta       = na_reg ? -tes_pkg::det_t'(pa_reg) : tes_pkg::det_t'(pa_reg);
        tb       = nb_reg ? -tes_pkg::det_t'(pb_reg) : tes_pkg::det_t'(pb_reg);
        det_next = ta - tb;
        abs_det  = det_reg[tes_pkg::DET_W-1] ? -det_reg : det_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                p1_vld_reg <= vertex_valid;
            end
            if (en2)
            begin
                p2_vld_reg <= p1_vld_reg;
            end
            if (en3)
            begin
                p3_vld_reg <= p2_vld_reg;
            end
            if (en4)
            begin
                p4_vld_reg <= p3_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p1_item_reg <= vertex_item;
        end
        if (en2)
        begin
            gb2_reg[0] <= tes_pkg::diff_t'(p1_item_reg.vertex1_y)
                        - tes_pkg::diff_t'(p1_item_reg.vertex2_y);
            gb2_reg[1] <= tes_pkg::diff_t'(p1_item_reg.vertex2_y)
                        - tes_pkg::diff_t'(p1_item_reg.vertex0_y);
            gb2_reg[2] <= tes_pkg::diff_t'(p1_item_reg.vertex0_y)
                        - tes_pkg::diff_t'(p1_item_reg.vertex1_y);
            gc2_reg[0] <= tes_pkg::diff_t'(p1_item_reg.vertex2_x)
                        - tes_pkg::diff_t'(p1_item_reg.vertex1_x);
            gc2_reg[1] <= tes_pkg::diff_t'(p1_item_reg.vertex0_x)
                        - tes_pkg::diff_t'(p1_item_reg.vertex2_x);
            gc2_reg[2] <= tes_pkg::diff_t'(p1_item_reg.vertex1_x)
                        - tes_pkg::diff_t'(p1_item_reg.vertex0_x);
            dx2_reg    <= tes_pkg::diff_t'(p1_item_reg.vertex2_x)
                        - tes_pkg::diff_t'(p1_item_reg.vertex0_x);
            dy1_reg    <= tes_pkg::diff_t'(p1_item_reg.vertex1_y)
                        - tes_pkg::diff_t'(p1_item_reg.vertex0_y);
        end
        if (en3)
        begin
            gb3_reg <= gb2_reg;
            gc3_reg <= gc2_reg;
            pa_reg  <= pa_full[tes_pkg::PROD_W-1:0];
            pb_reg  <= pb_full[tes_pkg::PROD_W-1:0];
            na_reg  <= gc2_reg[2][tes_pkg::DIFF_W-1] ^ gb2_reg[1][tes_pkg::DIFF_W-1];
            nb_reg  <= dx2_reg[tes_pkg::DIFF_W-1] ^ dy1_reg[tes_pkg::DIFF_W-1];
        end
        if (en4)
        begin
            gb4_reg <= gb3_reg;
            gc4_reg <= gc3_reg;
            det_reg <= det_next;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: walk the 36 entries of the held triangle
    // ------------------------------------------------------------------------
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (col_reg == tes_pkg::LAST_DOF)
        begin
            col_next = '0;
            row_next = row_reg + tes_pkg::dof_t'(1);
        end
        else
        begin
            col_next = col_reg + tes_pkg::dof_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_vld_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else if (seq_take)
        begin
            seq_vld_reg <= p4_vld_reg;
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else if (adv)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            gbs_reg    <= gb4_reg;
            gcs_reg    <= gc4_reg;
            dens_reg   <= {abs_det[tes_pkg::DET_W-2:0], 1'b0};
            degens_reg <= (det_reg == '0);
        end
    end

    // ------------------------------------------------------------------------
    // entry pipeline: numerator of each stiffness entry
    // ------------------------------------------------------------------------
    always_comb
    begin
        gbi       = tes_pkg::pick3(gbs_reg[0], gbs_reg[1], gbs_reg[2], row_reg[2:1]);
        gci       = tes_pkg::pick3(gcs_reg[0], gcs_reg[1], gcs_reg[2], row_reg[2:1]);
        gbj       = tes_pkg::pick3(gbs_reg[0], gbs_reg[1], gbs_reg[2], col_reg[2:1]);
        gcj       = tes_pkg::pick3(gcs_reg[0], gcs_reg[1], gcs_reg[2], col_reg[2:1]);
        row_odd   = row_reg[0];
        col_odd   = col_reg[0];
        tag1_next = '{row: row_reg, col: col_reg, last: seq_last, degen: degens_reg};
        m1_full   = tes_pkg::wprod_t'(tes_pkg::abs_diff(s_reg))
                  * tes_pkg::wprod_t'(tes_pkg::abs_diff(t_reg));
        m2_full   = tes_pkg::wprod_t'(tes_pkg::abs_diff(u_reg))
                  * tes_pkg::wprod_t'(tes_pkg::abs_diff(v_reg));
        num_next  = (n1_reg[4] ? -tes_pkg::num_t'(p1_reg) : tes_pkg::num_t'(p1_reg))
                  + (n2_reg[4] ? -tes_pkg::num_t'(p2_reg) : tes_pkg::num_t'(p2_reg));
        shifted   = tes_pkg::sdiv_t'(num_reg) <<< SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 6; s++)
            begin
                e_vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            e_vld_reg[1] <= seq_vld_reg;
            for (int s = 1; s < 6; s++)
            begin
                e_vld_reg[s+1] <= e_vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_tag_reg[1] <= tag1_next;
            e_den_reg[1] <= dens_reg;
            for (int s = 1; s < 6; s++)
            begin
                e_tag_reg[s+1] <= e_tag_reg[s];
                e_den_reg[s+1] <= e_den_reg[s];
            end
            s_reg   <= row_odd ? gci : gbi;
            t_reg   <= col_odd ? gcj : gbj;
            u_reg   <= row_odd ? gbi : gci;
            v_reg   <= col_odd ? gbj : gcj;
            ca1_reg <= (row_odd == col_odd) ? lp2 : tes_pkg::coefa_t'(lambda_reg);
            m1_reg    <= m1_full[tes_pkg::PROD_W-1:0];
            m2_reg    <= m2_full[tes_pkg::PROD_W-1:0];
            n1_reg[2] <= s_reg[tes_pkg::DIFF_W-1] ^ t_reg[tes_pkg::DIFF_W-1];
            n2_reg[2] <= u_reg[tes_pkg::DIFF_W-1] ^ v_reg[tes_pkg::DIFF_W-1];
            ca2_reg   <= ca1_reg;
            for (int s = 2; s < 4; s++)
            begin
                n1_reg[s+1] <= n1_reg[s];
                n2_reg[s+1] <= n2_reg[s];
            end
            alo_reg <= tes_pkg::pp_t'(m1_reg[31:0]) * tes_pkg::pp_t'(ca2_reg);
            ahi_reg <= tes_pkg::pp_t'(m1_reg[63:32]) * tes_pkg::pp_t'(ca2_reg);
            blo_reg <= tes_pkg::pp_t'(m2_reg[31:0]) * tes_pkg::pp_t'(mu_reg);
            bhi_reg <= tes_pkg::pp_t'(m2_reg[63:32]) * tes_pkg::pp_t'(mu_reg);
            p1_reg  <= (tes_pkg::term_t'(ahi_reg) << 32) + tes_pkg::term_t'(alo_reg);
            p2_reg  <= (tes_pkg::term_t'(bhi_reg) << 32) + tes_pkg::term_t'(blo_reg);
            num_reg <= num_next;
            neg6_reg <= num_reg[tes_pkg::NUM_W-1];
            mag_reg  <= num_reg[tes_pkg::NUM_W-1] ? tes_pkg::udiv_t'(-shifted)
                                                  : tes_pkg::udiv_t'(shifted);
        end
    end

    // ------------------------------------------------------------------------
    // divide by twice the absolute determinant
    // ------------------------------------------------------------------------
    assign div_in = '{dividend: mag_reg, den: e_den_reg[6], neg: neg6_reg,
                      tag: e_tag_reg[6]};

    tes_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e_vld_reg[6]),
        .div_in    (div_in),
        .out_valid (div_vld),
        .div_out   (div_out)
    );

    assign entry_valid = div_vld;
    assign entry_item  = '{row_index:   div_out.tag.row,
                           col_index:   div_out.tag.col,
                           entry_value: div_out.tag.degen ? '0 : div_out.value,
                           last_entry:  div_out.tag.last,
                           degenerate:  div_out.tag.degen};

    `TES_ASSERT_NEXT(a_issue_enters_pipe, clk, rst_n, seq_vld_reg && adv, e_vld_reg[1])
    `TES_ASSERT_IMPLY(a_last_is_corner, clk, rst_n, entry_valid && entry_item.last_entry,
                      entry_item.row_index == tes_pkg::LAST_DOF
                      && entry_item.col_index == tes_pkg::LAST_DOF)
    `TES_ASSERT_NEXT(a_load_restarts, clk, rst_n, seq_take && p4_vld_reg,
                     seq_vld_reg && row_reg == '0 && col_reg == '0)

endmodule
